// ===== rtl/slotted_page_record_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Slotted page record engine - assertion macros
// Shared concurrent assertion forms used by the core.
// ----------------------------------------------------------------------------
`ifndef SLOTTED_PAGE_RECORD_ENGINE_CORE_ASSERT_SVH
`define SLOTTED_PAGE_RECORD_ENGINE_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define SPRE_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("spre: invariant violated");

// antecedent at one edge implies consequent at the next
`define SPRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spre: sequence violated");

`endif

// ===== rtl/spre_pkg.sv =====
// ----------------------------------------------------------------------------
// Slotted page record engine - package
// Function and status codes, field widths and default page geometry.
// ----------------------------------------------------------------------------
package spre_pkg;

   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int SLOT_BYTES_DEF   = 4;
   localparam int MAX_SLOTS_DEF    = 1024;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_INSERT = 3'd1,
      FUNC_READ   = 3'd2,
      FUNC_DELETE = 3'd3,
      FUNC_QUERY  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_SLOT = 2'd2,
      STATUS_BAD_BYTE = 2'd3
   } status_type;

endpackage

// ===== rtl/spre_ram.sv =====
// ----------------------------------------------------------------------------
// Slotted page record engine - generic RAM
// One write port, one read port with registered, read-enabled output.
// ----------------------------------------------------------------------------
module spre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/slotted_page_record_engine_core.sv =====
// ----------------------------------------------------------------------------
// Slotted page record engine - top level
// Page store with upward-growing records and a downward slot directory.
// ----------------------------------------------------------------------------
// Use: each req item carries a function (tuser), operands (tdata) and the
// final-byte mark of an insert (tlast). Every item yields exactly one rsp
// item with status, slot, read byte, length and page usage.
// Inserts stream one byte per item; the first byte runs the space check.
// Reads return one byte of a live slot; deletes mark slots dead in place.
// An accepted item passes the input stage, the slot directory read and the
// record byte read before it is presented on rsp. Throughput: one item per
// cycle unless rsp stalls; the slot directory RAM and the record RAM are
// each read once per item in successive stages, so nothing recirculates.
// Reset has the effect of a clear page item: counters return to empty and
// no RAM contents are touched, so items are taken from the first cycle.
// A stalled rsp side holds the whole pipeline and drops req_tready in the
// same cycle; no item is lost or repeated.
// ----------------------------------------------------------------------------
module slotted_page_record_engine_core #(
   parameter int PAGE_BYTES   = spre_pkg::PAGE_BYTES_DEF,
   parameter int HEADER_BYTES = spre_pkg::HEADER_BYTES_DEF,
   parameter int SLOT_BYTES   = spre_pkg::SLOT_BYTES_DEF,
   parameter int MAX_SLOTS    = spre_pkg::MAX_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot_index[9:0], byte_index[21:10], record_length[33:22],
   // data_byte[41:34], zero fill
   input  logic [spre_pkg::REQ_DATA_W-1:0] req_tdata,
   // func[2:0]
   input  logic [2:0]                      req_tuser,
   // last_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], slot_id[11:2], read_byte[19:12], stored_length[31:20],
   // used_bytes[44:32], free_bytes[57:45], slots_in_use[68:58], zero fill
   output logic [spre_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import spre_pkg::*;

   localparam int AW  = $clog2(PAGE_BYTES);
   localparam int FW  = $clog2(PAGE_BYTES + 1);
   localparam int SAW = $clog2(MAX_SLOTS);
   localparam int TW  = $clog2(MAX_SLOTS + 1);
   localparam int UW  = $clog2(PAGE_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES + 4096 + 1);
   localparam int MW  = 1 + 12 + AW;

   // pipeline control
   logic advance;

   // input stage
   logic        v1_ff;
   logic [2:0]  func_ff;
   logic [9:0]  sidx_ff;
   logic [11:0] bidx_ff;
   logic [11:0] len_ff;
   logic [7:0]  data_ff;
   logic        last_ff;

   // page state
   logic [TW-1:0] total_ff, total_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          busy_ff, busy_in;
   logic          rej_ff, rej_in;
   logic [11:0]   pos_ff, pos_in;
   logic [AW-1:0] cur_off_ff, cur_off_in;
   logic [11:0]   cur_len_ff, cur_len_in;

   // stage 1 results
   logic [1:0]    status1;
   logic [9:0]    sid1;
   logic [11:0]   slen1;
   logic          range_bad1;
   logic [UW-1:0] need1;
   logic [UW-1:0] used1;
   logic [UW-1:0] free1;
   logic [UW-1:0] used_now;

   // RAM ports
   logic           meta_we, fcnt_we, store_we;
   logic [SAW-1:0] meta_wa, fcnt_wa, slot_ra;
   logic [MW-1:0]  meta_wd, meta_rd;
   logic [11:0]    fcnt_wd, fcnt_rd;
   logic [AW-1:0]  store_wa, store_ra;
   logic [7:0]     store_wd, store_rd;

   // stage 2
   logic        v2_ff;
   logic        read2_ff;
   logic        range_bad2_ff;
   logic [1:0]  status2_ff;
   logic [9:0]  sid2_ff;
   logic [11:0] slen2_ff;
   logic [11:0] bidx2_ff;
   logic [12:0] used2_ff;
   logic [12:0] free2_ff;
   logic [10:0] slots2_ff;
   logic [1:0]  status2;
   logic [11:0] slen2;
   logic        zero2;
   logic          m_live;
   logic [11:0]   m_len;
   logic [AW-1:0] m_off;

   // stage 3
   logic        v3_ff;
   logic [1:0]  status3_ff;
   logic [9:0]  sid3_ff;
   logic [11:0] slen3_ff;
   logic [12:0] used3_ff;
   logic [12:0] free3_ff;
   logic [10:0] slots3_ff;
   logic        zero3_ff;
   logic [7:0]  rbyte3;

   assign advance    = !v3_ff || rsp_tready;
   assign req_tready = advance;

   // ---- stage 1: state update and RAM writes
   always_comb begin
      total_in   = total_ff;
      fill_in    = fill_ff;
      busy_in    = busy_ff;
      rej_in     = rej_ff;
      pos_in     = pos_ff;
      cur_off_in = cur_off_ff;
      cur_len_in = cur_len_ff;
      status1    = STATUS_OK;
      sid1       = '0;
      slen1      = '0;
      meta_we    = 1'b0;
      meta_wa    = SAW'(total_ff);
      meta_wd    = {1'b1, len_ff, AW'(fill_ff)};
      fcnt_we    = 1'b0;
      fcnt_wa    = SAW'(total_ff);
      fcnt_wd    = (len_ff != 12'd0) ? 12'd1 : 12'd0;
      store_we   = 1'b0;
      store_wa   = AW'(fill_ff);
      store_wd   = data_ff;
      range_bad1 = (32'(sidx_ff) >= 32'(total_ff)) || (32'(sidx_ff) >= 32'(MAX_SLOTS));
      need1      = UW'(fill_ff) + (UW'(total_ff) + UW'(1)) * UW'(SLOT_BYTES) + UW'(len_ff);

      if (v1_ff && advance) begin
         unique case (func_ff)
            FUNC_CLEAR: begin
               total_in = '0;
               fill_in  = FW'(HEADER_BYTES);
               busy_in  = 1'b0;
               rej_in   = 1'b0;
               pos_in   = '0;
            end
            FUNC_INSERT: begin
               if (!busy_ff) begin
                  if ((32'(total_ff) >= 32'(MAX_SLOTS)) || (need1 > UW'(PAGE_BYTES))) begin
                     status1 = STATUS_NO_SPACE;
                     if (!last_ff) begin
                        busy_in = 1'b1;
                        rej_in  = 1'b1;
                     end
                  end else begin
                     meta_we    = 1'b1;
                     fcnt_we    = 1'b1;
                     store_we   = (len_ff != 12'd0);
                     pos_in     = (len_ff != 12'd0) ? 12'd1 : 12'd0;
                     cur_off_in = AW'(fill_ff);
                     cur_len_in = len_ff;
                     fill_in    = fill_ff + FW'(len_ff);
                     total_in   = total_ff + TW'(1);
                     sid1       = 10'(total_ff);
                     slen1      = len_ff;
                     busy_in    = !last_ff;
                  end
               end else begin
                  if (rej_ff) begin
                     status1 = STATUS_NO_SPACE;
                  end else begin
                     if (pos_ff < cur_len_ff) begin
                        store_we = 1'b1;
                        store_wa = AW'(32'(cur_off_ff) + 32'(pos_ff));
                        fcnt_we  = 1'b1;
                        fcnt_wa  = SAW'(total_ff - TW'(1));
                        fcnt_wd  = pos_ff + 12'd1;
                        pos_in   = pos_ff + 12'd1;
                     end
                     sid1  = 10'(total_ff - TW'(1));
                     slen1 = cur_len_ff;
                  end
                  if (last_ff) begin
                     busy_in = 1'b0;
                     rej_in  = 1'b0;
                  end
               end
            end
            FUNC_DELETE: begin
               if (range_bad1) begin
                  status1 = STATUS_BAD_SLOT;
               end else begin
                  meta_we = 1'b1;
                  meta_wa = SAW'(sidx_ff);
                  meta_wd = '0;
                  if (32'(sidx_ff) == 32'(total_ff) - 32'd1) begin
                     cur_len_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      used1 = UW'(fill_in) + UW'(total_in) * UW'(SLOT_BYTES);
      free1 = (used1 < UW'(PAGE_BYTES)) ? UW'(PAGE_BYTES) - used1 : '0;
   end

   assign used_now = UW'(fill_ff) + UW'(total_ff) * UW'(SLOT_BYTES);
   assign slot_ra  = SAW'(sidx_ff);

   spre_ram #(.WIDTH(MW), .DEPTH(MAX_SLOTS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_en   (advance),
      .rd_addr (slot_ra),
      .rd_data (meta_rd)
   );

   spre_ram #(.WIDTH(12), .DEPTH(MAX_SLOTS)) u_fcnt_ram (
      .clock   (clock),
      .wr_en   (fcnt_we),
      .wr_addr (fcnt_wa),
      .wr_data (fcnt_wd),
      .rd_en   (advance),
      .rd_addr (slot_ra),
      .rd_data (fcnt_rd)
   );

   // ---- stage 2: slot check and record byte address
   assign {m_live, m_len, m_off} = meta_rd;

   always_comb begin
      status2  = status2_ff;
      slen2    = slen2_ff;
      zero2    = 1'b1;
      store_ra = AW'(32'(m_off) + 32'(bidx2_ff));
      if (read2_ff) begin
         if (range_bad2_ff || !m_live) begin
            status2 = STATUS_BAD_SLOT;
         end else begin
            slen2 = m_len;
            if (bidx2_ff >= m_len) begin
               status2 = STATUS_BAD_BYTE;
            end else begin
               zero2 = (bidx2_ff >= fcnt_rd);
            end
         end
      end
   end

   spre_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_wa),
      .wr_data (store_wd),
      .rd_en   (advance),
      .rd_addr (store_ra),
      .rd_data (store_rd)
   );

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         total_ff <= '0;
         fill_ff  <= FW'(HEADER_BYTES);
         busy_ff  <= 1'b0;
         rej_ff   <= 1'b0;
         pos_ff   <= '0;
      end else begin
         total_ff <= total_in;
         fill_ff  <= fill_in;
         busy_ff  <= busy_in;
         rej_ff   <= rej_in;
         pos_ff   <= pos_in;
         if (advance) begin
            v1_ff <= req_tvalid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_off_ff <= cur_off_in;
      cur_len_ff <= cur_len_in;
      if (advance) begin
         func_ff       <= req_tuser;
         sidx_ff       <= req_tdata[9:0];
         bidx_ff       <= req_tdata[21:10];
         len_ff        <= req_tdata[33:22];
         data_ff       <= req_tdata[41:34];
         last_ff       <= req_tlast;
         read2_ff      <= (func_ff == FUNC_READ);
         range_bad2_ff <= range_bad1;
         status2_ff    <= status1;
         sid2_ff       <= sid1;
         slen2_ff      <= slen1;
         bidx2_ff      <= bidx_ff;
         used2_ff      <= 13'(used1);
         free2_ff      <= 13'(free1);
         slots2_ff     <= 11'(total_in);
         status3_ff    <= status2;
         sid3_ff       <= sid2_ff;
         slen3_ff      <= slen2;
         used3_ff      <= used2_ff;
         free3_ff      <= free2_ff;
         slots3_ff     <= slots2_ff;
         zero3_ff      <= zero2;
      end
   end

   assign rbyte3     = zero3_ff ? 8'd0 : store_rd;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {3'd0, slots3_ff, free3_ff, used3_ff, slen3_ff, rbyte3, sid3_ff,
                        status3_ff};

   `include "slotted_page_record_engine_core_assert.svh"

   `SPRE_ASSERT_ALWAYS(a_rej_in_insert, clock, reset, !rej_ff || busy_ff)
   `SPRE_ASSERT_ALWAYS(a_page_fits, clock, reset, used_now <= UW'(PAGE_BYTES))
   `SPRE_ASSERT_ALWAYS(a_dir_bound, clock, reset, 32'(total_ff) <= 32'(MAX_SLOTS))
   `SPRE_ASSERT_NEXT(a_stall_holds, clock, reset, v1_ff && !advance, v1_ff && $stable(func_ff))

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slotted page record engine - testbench
// Drives clear, insert, read, delete and query items into the core over its
// request stream and checks every response item against a page model kept
// here. A short table of hand-picked items comes first, then a long random
// run of record streams with reads, deletes and queries mixed in. Both
// streams idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb;
   import spre_pkg::*;

   localparam int unsigned PAGE_SIZE  = PAGE_BYTES_DEF;
   localparam int unsigned HEAD_SIZE  = HEADER_BYTES_DEF;
   localparam int unsigned SLOT_SIZE  = SLOT_BYTES_DEF;
   localparam int unsigned SLOT_LIMIT = MAX_SLOTS_DEF;
   localparam int          ITEM_GOAL  = 1100;
   localparam int          PROBE_ROWS = 25;

   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic [9:0]  slot_index;
      logic [11:0] byte_index;
      logic [11:0] record_length;
      logic [7:0]  data_byte;
      logic        last_byte;
   } page_op_t;

   typedef struct packed {
      status_type  status;
      logic [9:0]  slot_id;
      logic [7:0]  read_byte;
      logic [11:0] stored_length;
      logic [12:0] used_bytes;
      logic [12:0] free_bytes;
      logic [10:0] slots_in_use;
   } page_reply_t;

   typedef struct {
      page_op_t    op;
      bit          typed;
      status_type  t_status;
      int unsigned t_used;
      int unsigned t_slots;
   } probe_row_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [2:0]            req_tuser  = FUNC_QUERY;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   slotted_page_record_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // page model
   logic [7:0]  rec_mem  [PAGE_SIZE];
   bit          rec_set  [PAGE_SIZE];
   int unsigned dir_off  [SLOT_LIMIT];
   int unsigned dir_len  [SLOT_LIMIT];
   bit          dir_live [SLOT_LIMIT];
   int unsigned pg_fill;
   int unsigned pg_slots;
   bit          ins_open;
   bit          ins_dropped;
   int unsigned ins_pos;

   page_reply_t reply_q [$];
   int          faults     = 0;
   int          item_count = 0;
   bit          calm       = 1'b0;
   int          quiet_left = 0;

   probe_row_t probe_tab [PROBE_ROWS] = '{
      '{'{FUNC_QUERY,    10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_OK,       16, 0},
      '{'{FUNC_READ,     10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_BAD_SLOT, 16, 0},
      '{'{FUNC_DELETE,   10'd1023, 12'd0,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_BAD_SLOT, 16, 0},
      '{'{FUNC_SPARE_HI, 10'd1023, 12'd4095, 12'd4095, 8'hff, 1'b1}, 1'b1, STATUS_OK,       16, 0},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd2,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd2,    8'hff, 1'b1}, 1'b0, STATUS_OK,       0,  0},
      // zero length record
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd0,    8'h5a, 1'b1}, 1'b0, STATUS_OK,       0,  0},
      // early end: second byte never sent
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd2,    8'h3c, 1'b1}, 1'b0, STATUS_OK,       0,  0},
      // bytes past the length
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd1,    8'h11, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd1,    8'h22, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd1,    8'h33, 1'b1}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_READ,     10'd0,    12'd1,    12'd0,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_READ,     10'd0,    12'd2,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_BAD_BYTE, 37, 4},
      '{'{FUNC_READ,     10'd2,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      // refused record, then a dropped byte
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd4095, 8'h00, 1'b0}, 1'b1, STATUS_NO_SPACE, 37, 4},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd4095, 8'hff, 1'b1}, 1'b1, STATUS_NO_SPACE, 37, 4},
      // query in the middle of an open insert
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd2,    8'h77, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_QUERY,    10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd2,    8'h88, 1'b1}, 1'b0, STATUS_OK,       0,  0},
      // delete, delete of a dead slot, read of a dead slot
      '{'{FUNC_DELETE,   10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_DELETE,   10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_READ,     10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_BAD_SLOT, 43, 5},
      '{'{FUNC_READ,     10'd1023, 12'd4095, 12'd0,    8'h00, 1'b0}, 1'b1, STATUS_BAD_SLOT, 43, 5},
      // clear ends an open insert
      '{'{FUNC_INSERT,   10'd0,    12'd0,    12'd5,    8'h01, 1'b0}, 1'b0, STATUS_OK,       0,  0},
      '{'{FUNC_CLEAR,    10'd0,    12'd0,    12'd0,    8'h00, 1'b0}, 1'b1, STATUS_OK,       16, 0}
   };

   function automatic void page_clear();
      for (int i = 0; i < PAGE_SIZE; i++) begin
         rec_mem[i] = '0;
         rec_set[i] = 1'b0;
      end
      for (int i = 0; i < SLOT_LIMIT; i++) begin
         dir_off[i]  = 0;
         dir_len[i]  = 0;
         dir_live[i] = 1'b0;
      end
      pg_fill     = HEAD_SIZE;
      pg_slots    = 0;
      ins_open    = 1'b0;
      ins_dropped = 1'b0;
      ins_pos     = 0;
   endfunction

   function automatic void store_page_byte(input int unsigned addr, input logic [7:0] value);
      if (addr < PAGE_SIZE) begin
         rec_mem[addr] = value;
         rec_set[addr] = 1'b1;
      end
   endfunction

   // Advances the page model by one item. A read aimed at a page byte not
   // written since the last clear is moved past the record end.
   function automatic page_reply_t page_predict(inout page_op_t op);
      page_reply_t r;
      int unsigned need, s, len, used;
      r = '0;
      r.status = STATUS_OK;
      if (op.func == FUNC_READ && op.slot_index < pg_slots && dir_live[op.slot_index] &&
          op.byte_index < dir_len[op.slot_index] &&
          !rec_set[dir_off[op.slot_index] + op.byte_index])
         op.byte_index = dir_len[op.slot_index];
      case (op.func)
         FUNC_CLEAR: page_clear();
         FUNC_INSERT: begin
            if (!ins_open) begin
               len  = op.record_length;
               need = pg_fill + (pg_slots + 1) * SLOT_SIZE + len;
               if (pg_slots >= SLOT_LIMIT || need > PAGE_SIZE) begin
                  r.status = STATUS_NO_SPACE;
                  if (!op.last_byte) begin
                     ins_open    = 1'b1;
                     ins_dropped = 1'b1;
                  end
               end else begin
                  dir_off[pg_slots]  = pg_fill;
                  dir_len[pg_slots]  = len;
                  dir_live[pg_slots] = 1'b1;
                  if (len > 0)
                     store_page_byte(pg_fill, op.data_byte);
                  ins_pos         = (len > 0) ? 1 : 0;
                  pg_fill         = pg_fill + len;
                  r.slot_id       = pg_slots;
                  r.stored_length = len;
                  pg_slots        = pg_slots + 1;
                  ins_open        = !op.last_byte;
               end
            end else begin
               if (ins_dropped) begin
                  r.status = STATUS_NO_SPACE;
               end else if (pg_slots > 0) begin
                  s = pg_slots - 1;
                  if (ins_pos < dir_len[s]) begin
                     store_page_byte(dir_off[s] + ins_pos, op.data_byte);
                     ins_pos++;
                  end
                  r.slot_id       = s;
                  r.stored_length = dir_len[s];
               end
               if (op.last_byte) begin
                  ins_open    = 1'b0;
                  ins_dropped = 1'b0;
               end
            end
         end
         FUNC_READ: begin
            if (op.slot_index >= pg_slots || !dir_live[op.slot_index]) begin
               r.status = STATUS_BAD_SLOT;
            end else begin
               r.stored_length = dir_len[op.slot_index];
               if (op.byte_index >= dir_len[op.slot_index])
                  r.status = STATUS_BAD_BYTE;
               else
                  r.read_byte = rec_mem[dir_off[op.slot_index] + op.byte_index];
            end
         end
         FUNC_DELETE: begin
            if (op.slot_index >= pg_slots) begin
               r.status = STATUS_BAD_SLOT;
            end else begin
               dir_live[op.slot_index] = 1'b0;
               dir_len[op.slot_index]  = 0;
            end
         end
         default: ;
      endcase
      used           = pg_fill + pg_slots * SLOT_SIZE;
      r.used_bytes   = used;
      r.free_bytes   = (used < PAGE_SIZE) ? PAGE_SIZE - used : 0;
      r.slots_in_use = pg_slots;
      return r;
   endfunction

   // called just after a rising edge; returns just after the accepting edge
   task automatic drive_op(input page_op_t op);
      if (quiet_left > 0)
         quiet_left--;
      else if ($urandom_range(0, 39) == 0)
         quiet_left = $urandom_range(20, 80);
      if (!calm && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.func;
      req_tlast  <= op.last_byte;
      req_tdata  <= {6'd0, op.data_byte, op.record_length, op.byte_index, op.slot_index};
      do @(posedge clock); while (!req_tready);
      if (op.func <= FUNC_QUERY)
         item_count++;
   endtask

   task automatic send_op(input page_op_t op);
      reply_q.push_back(page_predict(op));
      drive_op(op);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_side_op();
      page_op_t op;
      int unsigned pick;
      pick             = $urandom_range(0, 99);
      op.slot_index    = $urandom_range(0, 1023);
      op.byte_index    = $urandom_range(0, 4095);
      op.record_length = $urandom_range(0, 4095);
      op.data_byte     = $urandom_range(0, 255);
      op.last_byte     = $urandom_range(0, 1);
      if (pick < 60) begin
         op.func = FUNC_READ;
         if (pg_slots > 0 && $urandom_range(0, 4) != 0) begin
            op.slot_index = $urandom_range(0, pg_slots - 1);
            if ($urandom_range(0, 3) != 0)
               op.byte_index = $urandom_range(0, dir_len[op.slot_index]);
         end
      end else if (pick < 75) begin
         op.func = FUNC_DELETE;
         if (pg_slots > 0 && $urandom_range(0, 3) != 0)
            op.slot_index = $urandom_range(0, pg_slots - 1);
      end else if (pick < 92) begin
         op.func = FUNC_QUERY;
      end else begin
         op.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      end
      send_op(op);
   endtask

   task automatic send_record();
      page_op_t op;
      int unsigned len, nbytes, pick, i;
      bit fits;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         len = 0;
      else if (pick < 75)
         len = $urandom_range(1, 12);
      else if (pick < 88)
         len = $urandom_range(13, 64);
      else if (pick < 96)
         len = $urandom_range(200, 1500);
      else
         len = $urandom_range(0, 4095);
      fits = !ins_open && pg_fill + (pg_slots + 1) * SLOT_SIZE + len <= PAGE_SIZE;
      pick = $urandom_range(0, 99);
      // long or refused records end early to keep the run short
      if (!fits || len > 64)
         nbytes = $urandom_range(1, 6);
      else if (pick < 10)
         nbytes = $urandom_range(1, (len == 0) ? 1 : len);
      else if (pick < 20)
         nbytes = len + $urandom_range(1, 3);
      else
         nbytes = (len == 0) ? 1 : len;
      for (i = 0; i < nbytes; i++) begin
         op.func          = FUNC_INSERT;
         op.slot_index    = $urandom_range(0, 1023);
         op.byte_index    = $urandom_range(0, 4095);
         op.record_length = (i > 0 && $urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) : len;
         op.data_byte     = $urandom_range(0, 255);
         op.last_byte     = (i == nbytes - 1);
         // now and then the record is left open
         if (op.last_byte && $urandom_range(0, 29) == 0)
            op.last_byte = 1'b0;
         send_op(op);
         if (i != nbytes - 1 && $urandom_range(0, 11) == 0)
            send_side_op();
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         faults++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // response side: check, then choose tready for the next cycle
   initial begin
      page_reply_t want;
      int stall_left, quiet;
      bit ready_next;
      stall_left = 0;
      quiet      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $error("response item with none expected");
               faults++;
            end else begin
               want = reply_q.pop_front();
               check_field("status",        want.status,        rsp_tdata[1:0]);
               check_field("slot_id",       want.slot_id,       rsp_tdata[11:2]);
               check_field("read_byte",     want.read_byte,     rsp_tdata[19:12]);
               check_field("stored_length", want.stored_length, rsp_tdata[31:20]);
               check_field("used_bytes",    want.used_bytes,    rsp_tdata[44:32]);
               check_field("free_bytes",    want.free_bytes,    rsp_tdata[57:45]);
               check_field("slots_in_use",  want.slots_in_use,  rsp_tdata[68:58]);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (quiet > 0) begin
            quiet--;
            ready_next = 1'b1;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 10);
            ready_next = 1'b0;
         end else begin
            if ($urandom_range(0, 39) == 0)
               quiet = $urandom_range(20, 80);
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      page_op_t op;
      page_reply_t want;
      int unsigned pick;
      bit drained;
      page_clear();
      drained = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < PROBE_ROWS; n++) begin
         op   = probe_tab[n].op;
         want = page_predict(op);
         if (probe_tab[n].typed) begin
            want.status       = probe_tab[n].t_status;
            want.used_bytes   = probe_tab[n].t_used;
            want.free_bytes   = PAGE_SIZE - probe_tab[n].t_used;
            want.slots_in_use = probe_tab[n].t_slots;
         end
         reply_q.push_back(want);
         drive_op(op);
      end
      drain_replies();

      item_count = 0;
      while (item_count < ITEM_GOAL) begin
         if (!drained && item_count > ITEM_GOAL / 2) begin
            drain_replies();
            drained = 1'b1;
         end
         calm = (item_count > ITEM_GOAL - 150);
         pick = $urandom_range(0, 399);
         if (pick < 180) begin
            send_record();
         end else if (pick < 398) begin
            send_side_op();
         end else begin
            op            = '0;
            op.func       = FUNC_CLEAR;
            op.slot_index = $urandom_range(0, 1023);
            send_op(op);
         end
      end

      drain_replies();
      repeat (8) @(posedge clock);
      if (faults == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
